/* hdl/nwtf_pkg.sv */
package nwtf_pkg;

  // Fixed-point constants of the fitting formula
  localparam logic [28:0] K043Q30 = 29'd461708984;   // 0.43 in Q30
  localparam logic [30:0] K18Q30  = 31'd1932735283;  // 1.8 in Q30
  localparam logic [29:0] Ln2Q30  = 30'd744261118;   // ln 2 in Q30
  localparam logic [24:0] TwoEQ22 = 25'd22802601;    // 2e in Q22
  localparam logic [25:0] C142Q22 = 26'd59559117;    // 14.2 in Q22
  localparam logic [9:0]  C731    = 10'd731;

  // Fraction bits of log2 produced by the squaring chain
  localparam int unsigned LogSteps = 30;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgHubble = 3'd0,
    CfgWm     = 3'd1,
    CfgSound  = 3'd2,
    CfgAlpha  = 3'd3,
    CfgTheta  = 3'd4
  } cfg_idx_e;

endpackage

/* hdl/nwtf_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// The partial remainder must start below the divisor.
module nwtf_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 32,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [TW-1:0] tag_i,
  output logic          out_valid_o,
  output logic [QW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_q [QW];
  logic [DW-1:0] div_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [TW-1:0] tag_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic          vld_in;
    logic [DW-1:0] div_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fit;

    if (g == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign div_in = divisor_i;
      assign rem_in = rem_i;
      assign low_in = low_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[g-1];
      assign div_in = div_q[g-1];
      assign rem_in = rem_q[g-1];
      assign low_in = low_q[g-1];
      assign quo_in = quo_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, div_in};
    assign fit   = (trial >= {1'b0, div_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= fit ? diff[DW-1:0] : trial[DW-1:0];
      div_q[g] <= div_in;
      low_q[g] <= low_in << 1;
      quo_q[g] <= {quo_in[QW-2:0], fit};
      tag_q[g] <= tag_in;
    end
  end

  assign out_valid_o = vld_q[QW-1];
  assign quot_o      = quo_q[QW-1];
  assign tag_o       = tag_q[QW-1];

endmodule

/* hdl/nwtf_log.sv */
// Pipelined natural log of a Q22 word (value at least 4.0), result in Q30.
// Normalize in two stages, then one squaring stage per fraction bit of
// log2, then scale by ln 2.
module nwtf_log
  import nwtf_pkg::*;
#(
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [43:0]   y_i,
  input  logic [TW-1:0] tag_i,
  output logic          out_valid_o,
  output logic [34:0]   ln_o,
  output logic [TW-1:0] tag_o
);

  // Leading-one position, input is known to be at least 2^24
  logic [5:0]    p_d;
  logic          va_q;
  logic [43:0]   ya_q;
  logic [5:0]    pa_q;
  logic [TW-1:0] taga_q;

  always_comb begin
    p_d = 6'd24;
    for (int i = 24; i < 44; i++) begin
      if (y_i[i]) p_d = 6'(i);
    end
  end

  // Shift the mantissa into [1,2) in Q30
  logic [43:0]   mfull;
  logic          vb_q;
  logic [30:0]   mb_q;
  logic [4:0]    eb_q;
  logic [TW-1:0] tagb_q;
  logic [5:0]    e_full;

  assign mfull  = (pa_q > 6'd30) ? (ya_q >> (pa_q - 6'd30)) : (ya_q << (6'd30 - pa_q));
  assign e_full = pa_q - 6'd22;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ya_q   <= y_i;
    pa_q   <= p_d;
    taga_q <= tag_i;
    mb_q   <= mfull[30:0];
    eb_q   <= e_full[4:0];
    tagb_q <= taga_q;
  end

  // Squaring chain, one log2 fraction bit per stage
  logic                vs_q  [LogSteps];
  logic [30:0]         ms_q  [LogSteps];
  logic [LogSteps-1:0] fs_q  [LogSteps];
  logic [4:0]          es_q  [LogSteps];
  logic [TW-1:0]       tags_q[LogSteps];

  for (genvar g = 0; g < LogSteps; g++) begin : g_sq
    logic                v_in;
    logic [30:0]         m_in;
    logic [LogSteps-1:0] f_in;
    logic [4:0]          e_in;
    logic [TW-1:0]       t_in;
    logic [61:0]         sq;
    logic [31:0]         sh;

    if (g == 0) begin : g_first
      assign v_in = vb_q;
      assign m_in = mb_q;
      assign f_in = '0;
      assign e_in = eb_q;
      assign t_in = tagb_q;
    end else begin : g_next
      assign v_in = vs_q[g-1];
      assign m_in = ms_q[g-1];
      assign f_in = fs_q[g-1];
      assign e_in = es_q[g-1];
      assign t_in = tags_q[g-1];
    end

    assign sq = 62'(m_in) * 62'(m_in);
    assign sh = sq[61:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[g] <= 1'b0;
      end else begin
        vs_q[g] <= v_in;
      end
    end

    // Halve when the square reaches 2.0 and record a one
    always_ff @(posedge clk_i) begin
      ms_q[g]   <= sh[31] ? sh[31:1] : sh[30:0];
      fs_q[g]   <= {f_in[LogSteps-2:0], sh[31]};
      es_q[g]   <= e_in;
      tags_q[g] <= t_in;
    end
  end

  // Scale log2 by ln 2
  logic [34:0]   lg;
  logic [64:0]   lp;
  logic          vo_q;
  logic [34:0]   ln_q;
  logic [TW-1:0] tago_q;

  assign lg = {es_q[LogSteps-1], fs_q[LogSteps-1]};
  assign lp = 65'(lg) * 65'(Ln2Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vs_q[LogSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ln_q   <= lp[64:30];
    tago_q <= tags_q[LogSteps-1];
  end

  assign out_valid_o = vo_q;
  assign ln_o        = ln_q;
  assign tag_o       = tago_q;

endmodule

/* hdl/no_wiggle_transfer_function.sv */
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+---------------------------
// command   | start_i, busy_o, wavenumber_i                | taken when start_i & !busy_o
// result    | done_o, transfer_value_o, invalid_o          | one-cycle strobe on done_o
// config    | cfg_we_i, cfg_idx_i, cfg_data_i              | written when cfg_we_i high
//
// One word is taken every cycle; busy_o stays low. The pipeline holds the
// four one-bit-per-stage dividers (31 + 42 + 32 + 31 stages) and the
// 33-stage log pipeline. Reset clears the valid bits and the config registers.
// The result side cannot stall, so the pipeline advances on every clock.
module no_wiggle_transfer_function
  import nwtf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] wavenumber_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] transfer_value_o,
  output logic        invalid_o
);

  // Configuration registers
  logic [31:0] hubble_q, wm_q, sound_q, alpha_q, theta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hubble_q <= '0;
      wm_q     <= '0;
      sound_q  <= '0;
      alpha_q  <= '0;
      theta_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHubble: hubble_q <= cfg_data_i;
        CfgWm:     wm_q     <= cfg_data_i;
        CfgSound:  sound_q  <= cfg_data_i;
        CfgAlpha:  alpha_q  <= cfg_data_i;
        CfgTheta:  theta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Front end: kM, x, x^2, x^4 partial products, divisor of the ratio
  logic        v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [33:0] km1_q, km2_q, km3_q, km4_q, km5_q, km6_q;
  logic [32:0] a2_q;
  logic [30:0] x3_q;
  logic [38:0] x24_q;
  logic [63:0] pll5_q;
  logic [38:0] phl5_q;
  logic [13:0] phh5_q;
  logic [55:0] rden6_q;

  logic [63:0] kprod;
  logic [62:0] aprod;
  logic [64:0] xprod;
  logic [42:0] xr;
  logic [30:0] x_d;
  logic [61:0] x2prod;
  logic [78:0] x4sum;

  assign kprod  = 64'(wavenumber_i) * 64'(hubble_q);
  assign aprod  = 63'(km1_q) * 63'(K043Q30);
  assign xprod  = 65'(a2_q) * 65'(sound_q);
  assign xr     = xprod[64:22];
  // Clamp x at 256.0, the ratio is already zero there
  assign x_d    = (xr > 43'(32'h4000_0000)) ? 31'h4000_0000 : xr[30:0];
  assign x2prod = 62'(x3_q) * 62'(x3_q);
  assign x4sum  = {1'b0, phh5_q, 64'b0} + {7'b0, phl5_q, 33'b0} + {15'b0, pll5_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    km1_q   <= kprod[63:30];
    km2_q   <= km1_q;
    a2_q    <= aprod[62:30];
    km3_q   <= km2_q;
    x3_q    <= x_d;
    km4_q   <= km3_q;
    x24_q   <= x2prod[60:22];
    km5_q   <= km4_q;
    pll5_q  <= 64'(x24_q[31:0]) * 64'(x24_q[31:0]);
    phl5_q  <= 39'(x24_q[38:32]) * 39'(x24_q[31:0]);
    phh5_q  <= 14'(x24_q[38:32]) * 14'(x24_q[38:32]);
    km6_q   <= km5_q;
    rden6_q <= 56'(32'h0040_0000) + 56'(x4sum[76:22]);
  end

  // Ratio r = 2^52 / (2^22 + x^4)
  logic        vr;
  logic [30:0] r_w;
  logic [33:0] kmr;

  nwtf_div #(.DW(56), .QW(31), .TW(34)) u_div_ratio (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v6_q),
    .divisor_i  (rden6_q),
    .rem_i      (56'(32'h0020_0000)),
    .low_i      ('0),
    .tag_i      (km6_q),
    .out_valid_o(vr),
    .quot_o     (r_w),
    .tag_o      (kmr)
  );

  // Effective shape, Gamma and the numerator of q
  logic               vs1_q, vs2_q, vg_q, vp_q;
  logic signed [64:0] sprod_q;
  logic signed [34:0] shape_q;
  logic [35:0]        num1_q, num2_q, numg_q, nump_q;
  logic [32:0]        gam_q, gamp_q;
  logic               invg_q, invp_q, capp_q;

  logic signed [32:0] ag_diff;
  logic signed [64:0] sprod;
  logic [65:0]        nprod;
  logic signed [34:0] shape_d;
  logic               shape_pos;
  logic [62:0]        gprod;
  logic [32:0]        gam_d;

  assign ag_diff   = 33'sh0_4000_0000 - $signed({alpha_q[31], alpha_q});
  assign sprod     = 65'(ag_diff) * $signed({34'b0, r_w});
  assign nprod     = 66'(kmr) * 66'(theta_q);
  assign shape_d   = $signed({{3{alpha_q[31]}}, alpha_q}) + $signed(sprod_q[64:30]);
  assign shape_pos = !shape_q[34] && (shape_q != '0);
  assign gprod     = 63'(wm_q) * 63'(shape_q[30:0]);
  assign gam_d     = shape_pos ? gprod[62:30] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs1_q <= 1'b0;
      vs2_q <= 1'b0;
      vg_q  <= 1'b0;
      vp_q  <= 1'b0;
    end else begin
      vs1_q <= vr;
      vs2_q <= vs1_q;
      vg_q  <= vs2_q;
      vp_q  <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sprod_q <= sprod;
    num1_q  <= nprod[65:30];
    shape_q <= shape_d;
    num2_q  <= num1_q;
    gam_q   <= gam_d;
    invg_q  <= (gam_d == '0);
    numg_q  <= num2_q;
    // Saturate q when the quotient would reach 2^20
    capp_q  <= ({9'b0, numg_q} >= {gam_q, 12'b0});
    gamp_q  <= gam_q;
    nump_q  <= numg_q;
    invp_q  <= invg_q;
  end

  // q = num * 2^30 / Gamma
  logic        vq;
  logic [41:0] qd_w;
  logic [1:0]  qtag;
  logic [42:0] q_w;

  nwtf_div #(.DW(33), .QW(42), .TW(2)) u_div_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vp_q),
    .divisor_i  (gamp_q),
    .rem_i      ({9'b0, nump_q[35:12]}),
    .low_i      ({nump_q[11:0], 30'b0}),
    .tag_i      ({capp_q, invp_q}),
    .out_valid_o(vq),
    .quot_o     (qd_w),
    .tag_o      (qtag)
  );

  assign q_w = qtag[1] ? 43'h400_0000_0000 : {1'b0, qd_w};

  // Log argument y = 2e + 1.8 q
  logic        vy1_q, vy2_q;
  logic [42:0] qy1_q, qy2_q;
  logic        invy1_q, invy2_q;
  logic [62:0] pql_q;
  logic [41:0] pqh_q;
  logic [43:0] y_q;
  logic [73:0] ysum;

  assign ysum = {pqh_q, 32'b0} + {11'b0, pql_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vy1_q <= 1'b0;
      vy2_q <= 1'b0;
    end else begin
      vy1_q <= vq;
      vy2_q <= vy1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qy1_q   <= q_w;
    invy1_q <= qtag[0];
    pql_q   <= 63'(q_w[31:0]) * 63'(K18Q30);
    pqh_q   <= 42'(q_w[42:32]) * 42'(K18Q30);
    qy2_q   <= qy1_q;
    invy2_q <= invy1_q;
    y_q     <= 44'(TwoEQ22) + ysum[73:30];
  end

  logic        vl;
  logic [34:0] ln_w;
  logic [43:0] ltag;

  nwtf_log #(.TW(44)) u_log (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vy2_q),
    .y_i        (y_q),
    .tag_i      ({qy2_q, invy2_q}),
    .out_valid_o(vl),
    .ln_o       (ln_w),
    .tag_o      (ltag)
  );

  // Divisor of the C term: 2^22 + 62.5 q
  logic        vc_q;
  logic [48:0] cden_q;
  logic [34:0] lnc_q;
  logic [42:0] qc_q;
  logic        invc_q;
  logic [49:0] q125;

  assign q125 = 50'(ltag[43:1]) * 50'(7'd125);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vl;
    end
  end

  always_ff @(posedge clk_i) begin
    cden_q <= 49'(32'h0040_0000) + q125[49:1];
    lnc_q  <= ln_w;
    qc_q   <= ltag[43:1];
    invc_q <= ltag[0];
  end

  logic        vcd;
  logic [31:0] cq_w;
  logic [78:0] ctag;

  nwtf_div #(.DW(49), .QW(32), .TW(79)) u_div_c (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vc_q),
    .divisor_i  (cden_q),
    .rem_i      (49'(C731) << 12),
    .low_i      ('0),
    .tag_i      ({lnc_q, qc_q, invc_q}),
    .out_valid_o(vcd),
    .quot_o     (cq_w),
    .tag_o      (ctag)
  );

  // C, q^2, C q^2 and the denominator
  logic        va_q, vb_q, vm_q, vn_q, vd_q;
  logic [32:0] ca_q, cb_q;
  logic [34:0] lna_q, lnb_q, lnm_q, lnn_q, lnd_q;
  logic        inva_q, invb_q, invm_q, invn_q, invd_q;
  logic [63:0] qll_q;
  logic [42:0] qhl_q;
  logic [21:0] qhh_q;
  logic [62:0] q2_q;
  logic [64:0] pcl_q;
  logic [63:0] pch_q;
  logic [63:0] cq2_q;
  logic [63:0] den_q;
  logic        eqd_q;
  logic [42:0] qcd;
  logic [86:0] qsum;
  logic [96:0] cprod;
  logic [64:0] dsum;

  assign qcd   = ctag[43:1];
  assign qsum  = {1'b0, qhh_q, 64'b0} + {11'b0, qhl_q, 33'b0} + {23'b0, qll_q};
  assign cprod = {1'b0, pch_q, 32'b0} + {32'b0, pcl_q};
  assign dsum  = 65'(lnn_q) + 65'(cq2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vm_q <= 1'b0;
      vn_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= vcd;
      vb_q <= va_q;
      vm_q <= vb_q;
      vn_q <= vm_q;
      vd_q <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q   <= 33'(C142Q22) + 33'(cq_w);
    lna_q  <= ctag[78:44];
    inva_q <= ctag[0];
    qll_q  <= 64'(qcd[31:0]) * 64'(qcd[31:0]);
    qhl_q  <= 43'(qcd[42:32]) * 43'(qcd[31:0]);
    qhh_q  <= 22'(qcd[42:32]) * 22'(qcd[42:32]);

    cb_q   <= ca_q;
    lnb_q  <= lna_q;
    invb_q <= inva_q;
    q2_q   <= qsum[84:22];

    lnm_q  <= lnb_q;
    invm_q <= invb_q;
    pcl_q  <= 65'(cb_q) * 65'(q2_q[31:0]);
    pch_q  <= 64'(cb_q) * 64'(q2_q[62:32]);

    lnn_q  <= lnm_q;
    invn_q <= invm_q;
    // Saturate C q^2 at all ones
    cq2_q  <= (cprod[96:78] != '0) ? '1 : cprod[77:14];

    lnd_q  <= lnn_q;
    invd_q <= invn_q;
    den_q  <= dsum[64] ? '1 : dsum[63:0];
    eqd_q  <= (cq2_q == '0);
  end

  // T = L * 2^31 / D
  logic        vt;
  logic [30:0] t_w;
  logic [1:0]  ttag;

  nwtf_div #(.DW(64), .QW(31), .TW(2)) u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vd_q),
    .divisor_i  (den_q),
    .rem_i      (64'(lnd_q)),
    .low_i      ('0),
    .tag_i      ({eqd_q, invd_q}),
    .out_valid_o(vt),
    .quot_o     (t_w),
    .tag_o      (ttag)
  );

  // Output word: zero when Gamma is zero (as on an invalid shape), exactly 1.0 when C q^2 vanishes
  logic        done_q;
  logic [31:0] tv_q;
  logic        inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vt;
    end
  end

  always_ff @(posedge clk_i) begin
    inv_q <= ttag[0];
    if (ttag[0]) begin
      tv_q <= '0;
    end else if (ttag[1]) begin
      tv_q <= 32'h8000_0000;
    end else begin
      tv_q <= {1'b0, t_w};
    end
  end

  assign done_o           = done_q;
  assign transfer_value_o = tv_q;
  assign invalid_o        = inv_q;

endmodule

/* bench/tb_no_wiggle_transfer_function.sv */
`timescale 1ns / 1ps

module tb_no_wiggle_transfer_function;
  import nwtf_pkg::*;

  localparam logic [2:0] CfgUnused  = 3'd7;
  localparam int unsigned Latency   = 188;
  localparam logic [63:0] OneQ30    = 64'd1 << 30;
  localparam logic [63:0] OneQ31    = 64'd1 << 31;
  localparam logic [63:0] XCapQ22   = 64'd1 << 30;
  localparam logic [63:0] QCapQ22   = 64'd1 << 42;
  localparam logic [63:0] AllOnes64 = {64{1'b1}};

  typedef struct packed {
    logic [31:0] transfer_value;
    logic        invalid;
  } transfer_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] wavenumber_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CfgHubble;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic [31:0] transfer_value_o;
  logic        invalid_o;

  // Shadow copy of the setup registers
  logic [31:0] hubble_q, wm_q, sound_q, alpha_q, theta_q;

  transfer_word_t transfer_expect_q[$];
  int unsigned err_count = 0;
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  int unsigned invalid_count = 0;
  int unsigned unity_count = 0;
  int unsigned zero_count = 0;
  bit idle_en = 1'b1;

  no_wiggle_transfer_function dut (.*);

  always #1 clk_i = ~clk_i;

  // floor(a*b / 2^sh), saturated to 64 bits
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] prod;
    prod = a * b;
    prod = prod >> sh;
    if (prod[127:64] != '0) return AllOnes64;
    return prod[63:0];
  endfunction

  // natural log of a Q22 value in Q30, via normalise and repeated squaring
  function automatic logic [63:0] ln_of_q22(logic [63:0] y);
    int          msb;
    logic [63:0] mant, frac, lg;
    msb = 63;
    while (msb > 0 && !y[msb]) msb--;
    mant = (msb > 30) ? (y >> (msb - 30)) : (y << (30 - msb));
    frac = '0;
    for (int i = 0; i < 30; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= OneQ31) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    lg = (64'(msb - 22) << 30) + frac;
    return mul_shift(lg, 64'(Ln2Q30), 30);
  endfunction

  // floor(num * 2^31 / den) for num < den
  function automatic logic [63:0] frac_q31(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem, res;
    rem = num;
    res = '0;
    for (int i = 0; i < 31; i++) begin
      res = res << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        res[0] = 1'b1;
      end else begin
        rem = rem + rem;
      end
    end
    return res;
  endfunction

  function automatic transfer_word_t eval_transfer(logic [31:0] kw);
    transfer_word_t w;
    logic [63:0] km, x, x2, x4, ratio, gam, num, q, y, lnv, cden, cval, q2, cq2, den;
    logic [63:0] tq;
    logic [64:0] den_sum;
    longint      ag, shape;
    km = (64'(kw) * 64'(hubble_q)) >> 30;
    x = mul_shift(mul_shift(km, 64'(K043Q30), 30), 64'(sound_q), 22);
    if (x > XCapQ22) x = XCapQ22;
    x2 = mul_shift(x, x, 22);
    x4 = mul_shift(x2, x2, 22);
    ratio = (64'd1 << 52) / ((64'd1 << 22) + x4);
    ag = longint'($signed(alpha_q));
    shape = ag + ((longint'(OneQ30) - ag) * longint'(ratio) >>> 30);
    gam = '0;
    if (shape > 0) gam = (64'(wm_q) * 64'(shape)) >> 30;
    // non-positive shape flags the word and zeroes it
    if (gam == '0) begin
      w.transfer_value = '0;
      w.invalid = 1'b1;
      return w;
    end
    num = mul_shift(km, 64'(theta_q), 30);
    if (num >= (gam << 12)) q = QCapQ22;
    else q = ((num / gam) << 30) + (((num % gam) << 30) / gam);
    y = 64'(TwoEQ22) + mul_shift(q, 64'(K18Q30), 30);
    lnv = ln_of_q22(y);
    cden = (64'd1 << 22) + ((q * 64'd125) >> 1);
    cval = 64'(C142Q22) + ((64'(C731) << 44) / cden);
    q2 = mul_shift(q, q, 22);
    cq2 = mul_shift(cval, q2, 14);
    den_sum = 65'(lnv) + 65'(cq2);
    den = den_sum[64] ? AllOnes64 : den_sum[63:0];
    w.invalid = 1'b0;
    tq = (den == lnv) ? OneQ31 : frac_q31(lnv, den);
    w.transfer_value = tq[31:0];
    return w;
  endfunction

  // Check each result word against the oldest prediction
  always @(negedge clk_i) begin
    transfer_word_t exp_w;
    if (rst_ni && done_o) begin
      got_count++;
      if (transfer_expect_q.size() == 0) begin
        $error("unexpected result word: transfer_value %0h invalid %0b",
               transfer_value_o, invalid_o);
        err_count++;
      end else begin
        exp_w = transfer_expect_q.pop_front();
        if (transfer_value_o !== exp_w.transfer_value) begin
          $error("transfer_value: expected %0h actual %0h",
                 exp_w.transfer_value, transfer_value_o);
          err_count++;
        end
        if (invalid_o !== exp_w.invalid) begin
          $error("invalid: expected %0b actual %0b", exp_w.invalid, invalid_o);
          err_count++;
        end
        if (exp_w.invalid) invalid_count++;
        else if (exp_w.transfer_value == OneQ31[31:0]) unity_count++;
        else if (exp_w.transfer_value == '0) zero_count++;
      end
    end
  end

  // Hold off until the pipeline is empty
  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (transfer_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Write one setup register; the pipeline must be empty
  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    drain_pipe();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgHubble: hubble_q = data;
      CfgWm:     wm_q = data;
      CfgSound:  sound_q = data;
      CfgAlpha:  alpha_q = data;
      CfgTheta:  theta_q = data;
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [31:0] h, logic [31:0] wm, logic [31:0] s,
                         logic [31:0] ag, logic [31:0] th);
    cfg_write(CfgHubble, h);
    cfg_write(CfgWm, wm);
    cfg_write(CfgSound, s);
    cfg_write(CfgAlpha, ag);
    cfg_write(CfgTheta, th);
  endtask

  // Send one word, with a random idle burst ahead of it at times
  task automatic send_word(logic [31:0] kw);
    int  gap;
    bit  ok;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    wavenumber_i <= kw;
    do begin
      @(negedge clk_i);
      ok = !busy_o;
      @(posedge clk_i);
    end while (!ok);
    transfer_expect_q.push_back(eval_transfer(kw));
    sent_count++;
  endtask

  function automatic logic [31:0] rand_wavenumber();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic test_reset_defaults();
    // all registers zero: every word is flagged
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    drain_pipe();
  endtask

  task automatic test_directed_typical();
    // h 0.7, wm 0.14, s 100 Mpc, ag 0.7, theta2 1.0186
    cfg_all(32'd751619277, 32'd150323855, 32'd419430400, 32'd751619277, 32'd1093721645);
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'd41943);
    send_word(32'd419430);
    send_word(32'd4194304);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    send_word(32'hFFFF_FFFF);
    // index outside the register file is dropped
    cfg_write(CfgUnused, 32'hDEAD_BEEF);
    send_word(32'd419430);
  endtask

  task automatic test_directed_extremes();
    // zero matter density flags the word
    cfg_all(32'd751619277, 32'd0, 32'd419430400, 32'd751619277, 32'd1093721645);
    send_word(32'd4194304);
    // strongly negative alpha makes the shape negative at high k
    cfg_all(32'd751619277, 32'd150323855, 32'd419430400, 32'h8000_0000, 32'd1093721645);
    send_word(32'd0);
    send_word(32'd4194304);
    send_word(32'hFFFF_FFFF);
    // tiny density, large theta: q saturates
    cfg_all(32'hFFFF_FFFF, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'd4194304);
    // everything at full scale
    cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
  endtask

  task automatic test_random_phase(int n, bit physical);
    if (physical)
      cfg_all($urandom_range(32'd429496730, 32'd1073741824),
              $urandom_range(32'd10737418, 32'd536870912),
              $urandom_range(32'd41943040, 32'd838860800),
              $urandom_range(0, 32'd1073741824),
              $urandom_range(32'd858993459, 32'd1288490189));
    else
      cfg_all($urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++) send_word(rand_wavenumber());
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_phase(150, 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    hubble_q = '0; wm_q = '0; sound_q = '0; alpha_q = '0; theta_q = '0;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_typical();
    test_directed_extremes();
    for (int p = 0; p < 7; p++) test_random_phase(200, p % 3 != 2);
    test_back_to_back();
    drain_pipe();
    repeat (Latency + 20) @(posedge clk_i);
    $display("covered %0d words (%0d results checked) over typical, full-scale and random setups",
             sent_count, got_count);
    $display("results: %0d flagged, %0d at unity, %0d truncated to zero",
             invalid_count, unity_count, zero_count);
    if (err_count == 0 && transfer_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
